FILE: src/cfc_pkg.sv
package cfc_pkg;

  localparam int BYTE_W         = 8;
  localparam int COUNT_W        = 9;
  localparam int SUM_W          = 16;
  localparam int STATUS_W       = 3;
  localparam int LEN_FIELD_W    = 5;
  localparam int GROUP_W        = 40;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 40;
  localparam int OUT_TDATA_W    = 32;
  localparam int MAX_PAYLOAD    = 32;
  localparam int NUM_COMMANDS   = 16;
  localparam int FRAME_OVERHEAD = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_HEADER   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_LENGTH   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_CHECKSUM = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TAIL     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_COMMAND  = 3'd5;

  localparam logic [CFG_ADDR_W-1:0] REG_HEADER_FIRST  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_HEADER_SECOND = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_TAIL_FIRST    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_TAIL_SECOND   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_MASK          = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_LENGTHS_LOW   = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_LENGTHS_HIGH  = 3'd6;

  typedef struct packed {
    logic              hdr_good;
    logic [BYTE_W-1:0] cmd;
    logic [BYTE_W-1:0] len;
    logic [SUM_W-1:0]  sum;
    logic [SUM_W-1:0]  rx_sum;
    logic              tail_good;
  } frame_t;

  localparam frame_t FRAME_CLEAR = '{
    hdr_good:  1'b1,
    cmd:       '0,
    len:       '0,
    sum:       '0,
    rx_sum:    '0,
    tail_good: 1'b1
  };

  typedef struct packed {
    logic [BYTE_W-1:0]  hdr_first;
    logic [BYTE_W-1:0]  hdr_second;
    logic [BYTE_W-1:0]  tail_first;
    logic [BYTE_W-1:0]  tail_second;
    logic [15:0]        cmd_mask;
    logic [GROUP_W-1:0] len_low;
    logic [GROUP_W-1:0] len_high;
  } cfg_t;

endpackage

FILE: src/cfc_verdict.sv
module cfc_verdict #(
  parameter int MAX_PAYLOAD = cfc_pkg::MAX_PAYLOAD
) (
  input  cfc_pkg::frame_t                    frm,
  input  logic [cfc_pkg::COUNT_W:0]          total,
  input  cfc_pkg::cfg_t                      cfg,
  output logic [cfc_pkg::STATUS_W-1:0]       status
);

  logic [cfc_pkg::GROUP_W-1:0]     group;
  logic [cfc_pkg::LEN_FIELD_W-1:0] cmd_len;
  logic [cfc_pkg::COUNT_W:0]       expect_total;
  logic                            cmd_bad;

  always_comb begin
    group   = frm.cmd[3] ? cfg.len_high : cfg.len_low;
    cmd_len = group[frm.cmd[2:0]*cfc_pkg::LEN_FIELD_W +: cfc_pkg::LEN_FIELD_W];
    expect_total = {{(cfc_pkg::COUNT_W+1-cfc_pkg::BYTE_W){1'b0}}, frm.len}
                   + (cfc_pkg::COUNT_W+1)'(cfc_pkg::FRAME_OVERHEAD);
    cmd_bad = (frm.cmd >= cfc_pkg::BYTE_W'(cfc_pkg::NUM_COMMANDS))
              || !cfg.cmd_mask[frm.cmd[3:0]]
              || (frm.len != {{(cfc_pkg::BYTE_W-cfc_pkg::LEN_FIELD_W){1'b0}}, cmd_len});
  end

  always_comb begin
    priority if (!frm.hdr_good || total < (cfc_pkg::COUNT_W+1)'(2)) begin
      status = cfc_pkg::ST_HEADER;
    end else if (total != expect_total || frm.len > cfc_pkg::BYTE_W'(MAX_PAYLOAD)) begin
      status = cfc_pkg::ST_LENGTH;
    end else if (frm.rx_sum != frm.sum) begin
      status = cfc_pkg::ST_CHECKSUM;
    end else if (!frm.tail_good) begin
      status = cfc_pkg::ST_TAIL;
    end else if (cmd_bad) begin
      status = cfc_pkg::ST_COMMAND;
    end else begin
      status = cfc_pkg::ST_OK;
    end
  end

endmodule

FILE: src/command_frame_checker_top.sv
// Channel | Dir | Handshake           | Payload
// in_     | in  | in_tvalid/in_tready | in_tdata: rx_byte; in_tlast: end_of_frame
// out_    | out | out_tvalid/out_tready | out_tdata: status, command, length, byte
//         |     |                     | out_tuser: byte_present; out_tlast: last_result
// cfg_    | in  | cfg_we              | cfg_addr: register index; cfg_wdata: value
//
// One byte per cycle while the result register is free; a byte is taken only then.
// A valid frame with nonzero payload L then reads the payload memory back, each result
// by a memory read and then a result register load, with input held off until done.
// Reset is synchronous and clears control, frame state and config registers, not the memory.
// A stalled result holds the result register and so holds off input.
module command_frame_checker_top #(
  parameter int MAX_PAYLOAD = cfc_pkg::MAX_PAYLOAD
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [cfc_pkg::BYTE_W-1:0]         in_tdata,   // [7:0] rx_byte
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [cfc_pkg::OUT_TDATA_W-1:0]    out_tdata,  // [2:0] frame_status,
                                                         // [10:3] command_type,
                                                         // [18:11] payload_length,
                                                         // [26:19] payload_byte
  output logic                               out_tuser,  // [0] byte_present
  output logic                               out_tlast,
  input  logic                               cfg_we,
  input  logic [cfc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [cfc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  localparam logic [1:0] S_RX   = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;

  logic [1:0]                        state_r, state_nxt;
  cfc_pkg::cfg_t                     cfg_r;
  cfc_pkg::frame_t                   frm_r, frm_nxt;
  logic [cfc_pkg::COUNT_W-1:0]       count_r, count_nxt;
  logic [cfc_pkg::COUNT_W-1:0]       rel;
  logic [cfc_pkg::COUNT_W-1:0]       len_ext;
  logic [cfc_pkg::COUNT_W:0]         total;
  logic [cfc_pkg::STATUS_W-1:0]      status;
  logic [cfc_pkg::BYTE_W-1:0]        mem [MAX_PAYLOAD];
  logic                              mem_we;
  logic [cfc_pkg::BYTE_W-1:0]        rd_data_r;
  logic [AW-1:0]                     rd_idx_r;
  logic [cfc_pkg::BYTE_W-1:0]        emit_cmd_r, emit_len_r;
  logic                              rd_last;
  logic                              in_acc, out_free;

  logic                              out_valid_r;
  logic [cfc_pkg::STATUS_W-1:0]      out_status_r;
  logic [cfc_pkg::BYTE_W-1:0]        out_cmd_r, out_len_r, out_byte_r;
  logic                              out_present_r, out_last_r;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_RX) && out_free;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        cfc_pkg::REG_HEADER_FIRST:  cfg_r.hdr_first   <= cfg_wdata[cfc_pkg::BYTE_W-1:0];
        cfc_pkg::REG_HEADER_SECOND: cfg_r.hdr_second  <= cfg_wdata[cfc_pkg::BYTE_W-1:0];
        cfc_pkg::REG_TAIL_FIRST:    cfg_r.tail_first  <= cfg_wdata[cfc_pkg::BYTE_W-1:0];
        cfc_pkg::REG_TAIL_SECOND:   cfg_r.tail_second <= cfg_wdata[cfc_pkg::BYTE_W-1:0];
        cfc_pkg::REG_MASK:          cfg_r.cmd_mask    <= cfg_wdata[15:0];
        cfc_pkg::REG_LENGTHS_LOW:   cfg_r.len_low     <= cfg_wdata;
        cfc_pkg::REG_LENGTHS_HIGH:  cfg_r.len_high    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // next frame state for the byte on the input
  always_comb begin
    frm_nxt = frm_r;
    mem_we  = 1'b0;
    rel     = count_r - cfc_pkg::COUNT_W'(4);
    len_ext = {{(cfc_pkg::COUNT_W-cfc_pkg::BYTE_W){1'b0}}, frm_r.len};
    priority if (count_r == cfc_pkg::COUNT_W'(0)) begin
      if (in_tdata != cfg_r.hdr_first) frm_nxt.hdr_good = 1'b0;
    end else if (count_r == cfc_pkg::COUNT_W'(1)) begin
      if (in_tdata != cfg_r.hdr_second) frm_nxt.hdr_good = 1'b0;
    end else if (count_r == cfc_pkg::COUNT_W'(2)) begin
      frm_nxt.cmd = in_tdata;
      frm_nxt.sum = frm_r.sum + {8'd0, in_tdata};
    end else if (count_r == cfc_pkg::COUNT_W'(3)) begin
      frm_nxt.len = in_tdata;
      frm_nxt.sum = frm_r.sum + {8'd0, in_tdata};
    end else if (rel < len_ext) begin
      frm_nxt.sum = frm_r.sum + {8'd0, in_tdata};
      mem_we      = in_acc && (rel < cfc_pkg::COUNT_W'(MAX_PAYLOAD));
    end else if (rel == len_ext) begin
      frm_nxt.rx_sum[15:8] = in_tdata;
    end else if (rel == len_ext + cfc_pkg::COUNT_W'(1)) begin
      frm_nxt.rx_sum[7:0] = in_tdata;
    end else if (rel == len_ext + cfc_pkg::COUNT_W'(2)) begin
      if (in_tdata != cfg_r.tail_first) frm_nxt.tail_good = 1'b0;
    end else if (rel == len_ext + cfc_pkg::COUNT_W'(3)) begin
      if (in_tdata != cfg_r.tail_second) frm_nxt.tail_good = 1'b0;
    end else begin
    end
    count_nxt = (count_r != cfc_pkg::COUNT_MAX) ? count_r + cfc_pkg::COUNT_W'(1) : count_r;
    total     = {1'b0, count_r} + (cfc_pkg::COUNT_W+1)'(1);
  end

  cfc_verdict #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_verdict (
    .frm    (frm_nxt),
    .total  (total),
    .cfg    (cfg_r),
    .status (status)
  );

  always_ff @(posedge clk) begin
    if (mem_we) mem[rel[AW-1:0]] <= in_tdata;
    if (state_r == S_READ) rd_data_r <= mem[rd_idx_r];
  end

  assign rd_last = ({{(cfc_pkg::BYTE_W-AW){1'b0}}, rd_idx_r} + cfc_pkg::BYTE_W'(1))
                   == emit_len_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_RX: begin
        if (in_acc && in_tlast && status == cfc_pkg::ST_OK
            && frm_nxt.len != '0) state_nxt = S_READ;
      end
      S_READ: state_nxt = S_LOAD;
      S_LOAD: begin
        if (out_free) state_nxt = rd_last ? S_RX : S_READ;
      end
      default: state_nxt = S_RX;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RX;
      frm_r       <= cfc_pkg::FRAME_CLEAR;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      rd_idx_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        if (in_tlast) begin
          frm_r   <= cfc_pkg::FRAME_CLEAR;
          count_r <= '0;
        end else begin
          frm_r   <= frm_nxt;
          count_r <= count_nxt;
        end
      end
      if (state_r == S_RX) begin
        rd_idx_r <= '0;
      end else if (state_r == S_LOAD && out_free) begin
        rd_idx_r <= rd_idx_r + AW'(1);
      end
      if ((in_acc && in_tlast && state_nxt == S_RX) || (state_r == S_LOAD && out_free)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_tlast) begin
      emit_cmd_r <= frm_nxt.cmd;
      emit_len_r <= frm_nxt.len;
      if (state_nxt == S_RX) begin
        out_status_r  <= status;
        out_cmd_r     <= frm_nxt.cmd;
        out_len_r     <= frm_nxt.len;
        out_byte_r    <= '0;
        out_present_r <= 1'b0;
        out_last_r    <= 1'b1;
      end
    end else if (state_r == S_LOAD && out_free) begin
      out_status_r  <= cfc_pkg::ST_OK;
      out_cmd_r     <= emit_cmd_r;
      out_len_r     <= emit_len_r;
      out_byte_r    <= rd_data_r;
      out_present_r <= 1'b1;
      out_last_r    <= rd_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_byte_r, out_len_r, out_cmd_r, out_status_r};
  assign out_tuser  = out_present_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: src/cfc_checker.sv
module cfc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [cfc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tuser,
  input logic                            out_tlast
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result dropped or changed");

  // a result without a byte closes the frame
  a_bare_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast && out_tdata[26:19] == 8'd0)
    else $error("result without byte not final or carries data");

  // a failure carries no byte
  a_fail_bare: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] != cfc_pkg::ST_OK |-> !out_tuser)
    else $error("failed frame emitted a payload byte");

  // a payload byte means its frame declared a nonzero length
  a_byte_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[18:11] != 8'd0)
    else $error("payload byte from zero-length frame");

endmodule

bind command_frame_checker_top cfc_checker u_cfc_checker (.*);

FILE: tb/sv/tb_command_frame_checker_top.sv
`timescale 1ns / 1ps

module tb_command_frame_checker_top;

  typedef struct {
    logic [cfc_pkg::STATUS_W-1:0] status;
    logic [cfc_pkg::BYTE_W-1:0]   cmd;
    logic [cfc_pkg::BYTE_W-1:0]   len;
    logic [cfc_pkg::BYTE_W-1:0]   data;
    logic                         present;
    logic                         last;
  } frame_result_t;

  typedef enum int {
    FR_GOOD,
    FR_BAD_HEADER,
    FR_BAD_SUM,
    FR_BAD_TAIL,
    FR_WRONG_LEN,
    FR_UNREGISTERED,
    FR_CMD_RANGE,
    FR_TRUNCATED,
    FR_OVERRUN,
    FR_OVERSIZE,
    FR_NOISE
  } frame_kind_t;

  class frame_scoreboard_t;
    logic [cfc_pkg::BYTE_W-1:0]  hdr_first, hdr_second, tail_first, tail_second;
    logic [15:0]                 cmd_mask;
    logic [cfc_pkg::GROUP_W-1:0] len_low, len_high;

    logic [cfc_pkg::COUNT_W-1:0] byte_count;
    logic                        hdr_ok, tail_ok;
    logic [cfc_pkg::BYTE_W-1:0]  frame_cmd, rx_len;
    logic [cfc_pkg::SUM_W-1:0]   running_sum, received_sum;
    logic [cfc_pkg::BYTE_W-1:0]  payload_mem [cfc_pkg::MAX_PAYLOAD];

    frame_result_t expected_q[$];
    int errors;
    int predicted;

    function new();
      hdr_first = '0;
      hdr_second = '0;
      tail_first = '0;
      tail_second = '0;
      cmd_mask = '0;
      len_low = '0;
      len_high = '0;
      errors = 0;
      predicted = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      byte_count = '0;
      hdr_ok = 1'b1;
      tail_ok = 1'b1;
      frame_cmd = '0;
      rx_len = '0;
      running_sum = '0;
      received_sum = '0;
    endfunction

    function void set_reg(logic [cfc_pkg::CFG_ADDR_W-1:0] idx,
                          logic [cfc_pkg::CFG_DATA_W-1:0] v);
      case (idx)
        cfc_pkg::REG_HEADER_FIRST:  hdr_first = v[7:0];
        cfc_pkg::REG_HEADER_SECOND: hdr_second = v[7:0];
        cfc_pkg::REG_TAIL_FIRST:    tail_first = v[7:0];
        cfc_pkg::REG_TAIL_SECOND:   tail_second = v[7:0];
        cfc_pkg::REG_MASK:          cmd_mask = v[15:0];
        cfc_pkg::REG_LENGTHS_LOW:   len_low = v[cfc_pkg::GROUP_W-1:0];
        cfc_pkg::REG_LENGTHS_HIGH:  len_high = v[cfc_pkg::GROUP_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [cfc_pkg::LEN_FIELD_W-1:0] cmd_len(logic [3:0] c);
      logic [cfc_pkg::GROUP_W-1:0] grp;
      grp = c[3] ? len_high : len_low;
      return grp[5*c[2:0] +: cfc_pkg::LEN_FIELD_W];
    endfunction

    function void push_result(logic [cfc_pkg::STATUS_W-1:0] st,
                              logic [cfc_pkg::BYTE_W-1:0] d,
                              logic present, logic last);
      frame_result_t r;
      r.status = st;
      r.cmd = frame_cmd;
      r.len = rx_len;
      r.data = d;
      r.present = present;
      r.last = last;
      expected_q.push_back(r);
      predicted++;
    endfunction

    function void note_byte(logic [cfc_pkg::BYTE_W-1:0] b, logic eof);
      int pos;
      int rel;
      int total;
      logic [cfc_pkg::STATUS_W-1:0] st;
      pos = byte_count;
      if (pos == 0) begin
        if (b != hdr_first) hdr_ok = 1'b0;
      end else if (pos == 1) begin
        if (b != hdr_second) hdr_ok = 1'b0;
      end else if (pos == 2) begin
        frame_cmd = b;
        running_sum = running_sum + b;
      end else if (pos == 3) begin
        rx_len = b;
        running_sum = running_sum + b;
      end else begin
        rel = pos - 4;
        if (rel < rx_len) begin
          running_sum = running_sum + b;
          if (rel < cfc_pkg::MAX_PAYLOAD) payload_mem[rel] = b;
        end else if (rel == rx_len) begin
          received_sum[15:8] = b;
        end else if (rel == rx_len + 1) begin
          received_sum[7:0] = b;
        end else if (rel == rx_len + 2) begin
          if (b != tail_first) tail_ok = 1'b0;
        end else if (rel == rx_len + 3) begin
          if (b != tail_second) tail_ok = 1'b0;
        end
      end
      if (byte_count != cfc_pkg::COUNT_MAX) byte_count = byte_count + 1'b1;
      if (!eof) return;

      total = pos + 1;
      if (!hdr_ok || total < 2) st = cfc_pkg::ST_HEADER;
      else if (total != rx_len + cfc_pkg::FRAME_OVERHEAD ||
               rx_len > cfc_pkg::MAX_PAYLOAD) st = cfc_pkg::ST_LENGTH;
      else if (received_sum != running_sum) st = cfc_pkg::ST_CHECKSUM;
      else if (!tail_ok) st = cfc_pkg::ST_TAIL;
      else if (frame_cmd >= cfc_pkg::NUM_COMMANDS || !cmd_mask[frame_cmd[3:0]] ||
               rx_len != cmd_len(frame_cmd[3:0])) st = cfc_pkg::ST_COMMAND;
      else st = cfc_pkg::ST_OK;

      if (st != cfc_pkg::ST_OK || rx_len == 0) begin
        push_result(st, '0, 1'b0, 1'b1);
      end else begin
        for (int i = 0; i < rx_len && i < cfc_pkg::MAX_PAYLOAD; i++)
          push_result(cfc_pkg::ST_OK, payload_mem[i], 1'b1, i + 1 == rx_len);
      end
      clear_frame();
    endfunction

    function void check_result(frame_result_t got);
      frame_result_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result st=%0d cmd=%02h len=%02h byte=%02h %0b%0b",
                 $time, got.status, got.cmd, got.len, got.data, got.present, got.last);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.status !== exp_r.status || got.cmd !== exp_r.cmd || got.len !== exp_r.len ||
          got.data !== exp_r.data || got.present !== exp_r.present ||
          got.last !== exp_r.last) begin
        $display("%0t: result mismatch: expected st=%0d cmd=%02h len=%02h byte=%02h %0b%0b",
                 $time, exp_r.status, exp_r.cmd, exp_r.len, exp_r.data, exp_r.present,
                 exp_r.last);
        $display("%0t:                  actual   st=%0d cmd=%02h len=%02h byte=%02h %0b%0b",
                 $time, got.status, got.cmd, got.len, got.data, got.present, got.last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [cfc_pkg::BYTE_W-1:0]      in_tdata = '0;
  logic                            in_tlast = 1'b0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [cfc_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            out_tuser;
  logic                            out_tlast;
  logic                            cfg_we = 1'b0;
  logic [cfc_pkg::CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [cfc_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

  frame_scoreboard_t sb = new();
  frame_result_t     seen_result;
  bit                tx_burst = 1'b0;
  bit                long_hold_req = 1'b0;

  command_frame_checker_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_result.status = out_tdata[2:0];
      seen_result.cmd = out_tdata[10:3];
      seen_result.len = out_tdata[18:11];
      seen_result.data = out_tdata[26:19];
      seen_result.present = out_tuser;
      seen_result.last = out_tlast;
      sb.check_result(seen_result);
    end
  end

  initial begin : result_sink
    int unsigned gap;
    int burst_left;
    burst_left = 0;
    forever begin
      if (long_hold_req) begin
        @(negedge clk);
        out_tready <= 1'b0;
        repeat (300) @(negedge clk);
        long_hold_req = 1'b0;
        out_tready <= 1'b1;
      end else begin
        if (burst_left > 0) begin
          gap = 0;
          burst_left--;
        end else begin
          gap = $urandom_range(0, 19);
          if ($urandom_range(0, 49) == 0) burst_left = 30;
        end
        @(negedge clk);
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        out_tready <= 1'b1;
      end
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send_byte(input logic [cfc_pkg::BYTE_W-1:0] b, input logic eof);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 19);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= eof;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(b, eof);
  endtask

  task automatic send_frame(input logic [cfc_pkg::BYTE_W-1:0] fr[$]);
    tx_burst = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < fr.size(); i++)
      send_byte(fr[i], i == fr.size() - 1);
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(input logic [cfc_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [cfc_pkg::CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= v;
    sb.set_reg(idx, v);
  endtask

  task automatic write_config(input logic [7:0] h1, input logic [7:0] h2,
                              input logic [7:0] t1, input logic [7:0] t2,
                              input logic [15:0] mask,
                              input logic [cfc_pkg::GROUP_W-1:0] lo,
                              input logic [cfc_pkg::GROUP_W-1:0] hi);
    write_reg(cfc_pkg::REG_HEADER_FIRST, h1);
    write_reg(cfc_pkg::REG_HEADER_SECOND, h2);
    write_reg(cfc_pkg::REG_TAIL_FIRST, t1);
    write_reg(cfc_pkg::REG_TAIL_SECOND, t2);
    write_reg(cfc_pkg::REG_MASK, mask);
    write_reg(cfc_pkg::REG_LENGTHS_LOW, lo);
    write_reg(cfc_pkg::REG_LENGTHS_HIGH, hi);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [cfc_pkg::LEN_FIELD_W-1:0] draw_length();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 31);
    return $urandom_range(0, 4);
  endfunction

  task automatic load_random_config();
    logic [cfc_pkg::GROUP_W-1:0] lo, hi;
    for (int c = 0; c < 8; c++) begin
      lo[5*c +: cfc_pkg::LEN_FIELD_W] = draw_length();
      hi[5*c +: cfc_pkg::LEN_FIELD_W] = draw_length();
    end
    write_config($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                 $urandom_range(0, 255), $urandom_range(1, 16'hFFFF), lo, hi);
  endtask

  function automatic logic [cfc_pkg::BYTE_W-1:0] pick_command(bit registered);
    logic [3:0] c;
    for (int k = 0; k < 64; k++) begin
      c = $urandom_range(0, 15);
      if (sb.cmd_mask[c] == registered) return c;
    end
    return registered ? $urandom_range(0, 15) : $urandom_range(16, 255);
  endfunction

  function automatic void build_frame(frame_kind_t kind,
                                      ref logic [cfc_pkg::BYTE_W-1:0] fr[$]);
    logic [cfc_pkg::BYTE_W-1:0] c, l;
    logic [cfc_pkg::SUM_W-1:0]  s;
    int n;
    fr.delete();
    if (kind == FR_NOISE) begin
      n = $urandom_range(1, 12);
      repeat (n) fr.push_back($urandom_range(0, 255));
      return;
    end
    c = pick_command(kind != FR_UNREGISTERED);
    l = (c < cfc_pkg::NUM_COMMANDS) ? sb.cmd_len(c[3:0]) : $urandom_range(0, 8);
    case (kind)
      FR_CMD_RANGE: begin
        c = $urandom_range(16, 255);
        l = $urandom_range(0, 8);
      end
      FR_WRONG_LEN: l = (sb.cmd_len(c[3:0]) + $urandom_range(1, 32)) % 33;
      FR_OVERSIZE:  l = $urandom_range(33, 40);
      default: ;
    endcase
    s = c + l;
    fr.push_back(sb.hdr_first);
    fr.push_back(sb.hdr_second);
    fr.push_back(c);
    fr.push_back(l);
    for (int i = 0; i < l; i++) begin
      fr.push_back($urandom_range(0, 255));
      s = s + fr[fr.size() - 1];
    end
    fr.push_back(s[15:8]);
    fr.push_back(s[7:0]);
    fr.push_back(sb.tail_first);
    fr.push_back(sb.tail_second);
    case (kind)
      FR_BAD_HEADER: begin
        n = $urandom_range(0, 1);
        fr[n] = fr[n] ^ (8'h01 << $urandom_range(0, 7));
      end
      FR_BAD_SUM: begin
        n = 4 + l + $urandom_range(0, 1);
        fr[n] = fr[n] ^ (8'h01 << $urandom_range(0, 7));
      end
      FR_BAD_TAIL: begin
        n = 6 + l + $urandom_range(0, 1);
        fr[n] = fr[n] ^ (8'h01 << $urandom_range(0, 7));
      end
      FR_TRUNCATED: begin
        n = $urandom_range(1, fr.size() - 1);
        while (fr.size() > n) void'(fr.pop_back());
      end
      FR_OVERRUN: repeat ($urandom_range(1, 6)) fr.push_back($urandom_range(0, 255));
      default: ;
    endcase
  endfunction

  task automatic run_random(input int budget);
    logic [cfc_pkg::BYTE_W-1:0] fr[$];
    frame_kind_t kind;
    int sent;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 99) < 60) kind = FR_GOOD;
      else kind = frame_kind_t'($urandom_range(FR_BAD_HEADER, FR_NOISE));
      build_frame(kind, fr);
      send_frame(fr);
      sent += fr.size();
    end
  endtask

  initial begin : stimulus
    logic [cfc_pkg::BYTE_W-1:0] fr[$];
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_config(8'hFF, 8'h00, 8'h00, 8'hFF, 16'h8001, '0, 40'd1 << 35);
    fr = '{8'hFF};
    send_frame(fr);
    fr = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF};
    send_frame(fr);
    fr = '{8'hFF, 8'h00, 8'h0F, 8'h01, 8'hFF, 8'h01, 8'h0F, 8'h00, 8'hFF};
    send_frame(fr);
    fr = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'hFF};
    send_frame(fr);

    wait_drain();
    write_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, '1, '1);
    run_random(50);

    wait_drain();
    write_config('0, '0, '0, '0, '0, '0, '0);
    run_random(30);

    wait_drain();
    load_random_config();
    long_hold_req = 1'b1;
    run_random(50);

    wait_drain();
    load_random_config();
    run_random(50);

    wait_drain();
    sb.errors += sb.pending();
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
